[hw/rtl/bol_pkg.sv]
package bol_pkg;

    // Field widths of the stream words
    localparam int ACTION_W  = 3;
    localparam int POS_W     = 4;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 5;
    localparam int CAP_W     = 5;
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;

    // Defaults for the top level parameters
    localparam int DEFAULT_DEPTH      = 16;
    localparam int DEFAULT_DATA_WIDTH = 32;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ERASE  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd5;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_PLACE,
        S_DONE
    } bol_state_t;

endpackage

[hw/rtl/bounded_ordered_list.sv]
// Bounded ordered list: a list of up to DEPTH data words kept in entry order.
// Requests enter on the s_ channel (action in s_tuser, position and value in
// s_tdata); one result word per request leaves on the m_ channel with the ok
// flag, the word read, the count and the full and empty flags.
// cfg_wr_en/cfg_wr_data set the capacity limit (resets to DEPTH); write it only
// while no request is in flight.
// Push, pop, read, clear, refused requests, an insert at the end and an erase
// of the last entry go straight to the reporting state; an erase that moves
// entries shifts them first, and an insert that moves entries shifts them and
// then places the new word. The entries sit in one memory with one read
// and one write port and a registered read, so shifting moves one entry per
// cycle, up to DEPTH-1 entries. A new request is taken only once the result of
// the last one has entered the output register, never while one is in progress.
// The output register holds a result while m_tready is low; the block then
// finishes the next request and waits with it until the register frees.
// Reset empties the list and leaves memory contents undefined; there is no
// clearing pass.
module bounded_ordered_list #(
    parameter int DEPTH      = bol_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = bol_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bol_pkg::CAP_W-1:0]     cfg_wr_data,   // capacity_limit
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bol_pkg::S_TDATA_W-1:0] s_tdata,       // position[3:0], value[35:4]
    input  logic [bol_pkg::S_TUSER_W-1:0] s_tuser,       // action[2:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bol_pkg::M_TDATA_W-1:0] m_tdata        // ok[0], read_value[32:1],
                                                         // count[37:33], is_full[38],
                                                         // is_empty[39]
);
    import bol_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Entry memory
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;

    // Control and request registers
    bol_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [LW-1:0]         cap_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic                  up_reg, up_next;
    logic                  ok_reg, ok_next;
    logic                  rdflag_reg, rdflag_next;

    // Input fields
    logic [ACTION_W-1:0]   in_action;
    logic [POS_W-1:0]      in_pos;
    logic [VALUE_W-1:0]    in_value;
    logic                  in_acc;

    // Derived compares
    logic [LW-1:0]         lim;
    logic [LW-1:0]         cnt_l;
    logic [LW-1:0]         pos_l;
    logic [CNT_W-1:0]      ptr_plus;
    logic                  room;
    logic [VALUE_W-1:0]    rd_word;

    assign in_action = s_tuser[ACTION_W-1:0];
    assign in_pos    = s_tdata[POS_W-1:0];
    assign in_value  = s_tdata[POS_W+VALUE_W-1:POS_W];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;

    // Effective limit is the smaller of the register and DEPTH
    assign lim      = (cap_reg < LW'(DEPTH)) ? cap_reg : LW'(DEPTH);
    assign cnt_l    = LW'(count_reg);
    assign pos_l    = LW'(in_pos);
    assign ptr_plus = CNT_W'(ptr_reg) + CNT_W'(1);
    assign room     = (cnt_l < lim);
    assign rd_word  = rdflag_reg ? VALUE_W'(rdata_reg) : '0;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Write and read the entry memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cap_reg      <= LW'(DEPTH);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= LW'(cfg_wr_data);
            end
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        ptr_reg     <= ptr_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        up_reg      <= up_next;
        ok_reg      <= ok_next;
        rdflag_reg  <= rdflag_next;
    end

    // Sequence one request: decide, shift, place, report
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ptr_next      = ptr_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        up_next       = up_reg;
        ok_next       = ok_reg;
        rdflag_next   = rdflag_reg;
        wr_en         = 1'b0;
        wr_addr       = ptr_reg;
        wr_data       = rdata_reg;
        rd_en         = 1'b0;
        rd_addr       = ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next  = S_DONE;
                    ok_next     = 1'b0;
                    rdflag_next = 1'b0;
                    pos_next    = AW'(in_pos);
                    val_next    = DATA_WIDTH'(in_value);
                    case (in_action)
                        ACT_PUSH:
                        begin
                            if (room)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = AW'(count_reg);
                                wr_data    = DATA_WIDTH'(in_value);
                                count_next = count_reg + CNT_W'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        ACT_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CNT_W'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        ACT_INSERT:
                        begin
                            if (room && pos_l <= cnt_l)
                            begin
                                ok_next = 1'b1;
                                if (pos_l == cnt_l)
                                begin
                                    // append without moving anything
                                    wr_en      = 1'b1;
                                    wr_addr    = AW'(in_pos);
                                    wr_data    = DATA_WIDTH'(in_value);
                                    count_next = count_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    // start moving from the last entry
                                    rd_en      = 1'b1;
                                    rd_addr    = AW'(count_reg - CNT_W'(1));
                                    ptr_next   = AW'(count_reg - CNT_W'(1));
                                    up_next    = 1'b1;
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        ACT_ERASE:
                        begin
                            if (pos_l < cnt_l)
                            begin
                                ok_next = 1'b1;
                                if (pos_l + LW'(1) == cnt_l)
                                begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                                else
                                begin
                                    // start moving from the entry above the hole
                                    rd_en      = 1'b1;
                                    rd_addr    = AW'(in_pos) + AW'(1);
                                    ptr_next   = AW'(in_pos) + AW'(1);
                                    up_next    = 1'b0;
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        ACT_READ:
                        begin
                            if (pos_l < cnt_l)
                            begin
                                rd_en       = 1'b1;
                                rd_addr     = AW'(in_pos);
                                ok_next     = 1'b1;
                                rdflag_next = 1'b1;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                            ok_next    = 1'b1;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                // move the entry read last cycle one place
                wr_en   = 1'b1;
                wr_data = rdata_reg;
                if (up_reg)
                begin
                    wr_addr = ptr_reg + AW'(1);
                    if (ptr_reg == pos_reg)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = ptr_reg - AW'(1);
                        ptr_next = ptr_reg - AW'(1);
                    end
                end
                else
                begin
                    wr_addr = ptr_reg - AW'(1);
                    if (ptr_plus == count_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = ptr_reg + AW'(1);
                        ptr_next = ptr_reg + AW'(1);
                    end
                end
            end
            S_PLACE:
            begin
                // drop the new word into the opened slot
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = val_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hand the result word to the output register once it frees
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(count_reg == '0), (cnt_l >= lim),
                                     COUNT_W'(count_reg), rd_word, ok_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // A shift never reads and writes the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write hit the same entry");

    // An accepted request always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg != S_IDLE))
        else $error("accepted request did not start");

    // Reporting loads the output and returns to idle
    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!m_tvalid_reg || m_tready))
        |=> (m_tvalid_reg && state_reg == S_IDLE))
        else $error("result not loaded");

    // The count does not move while a result waits
    a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> $stable(count_reg))
        else $error("count changed while reporting");

    // The count is within the list depth whenever a request is accepted
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (LW'(count_reg) <= LW'(DEPTH)))
        else $error("count beyond depth");
`endif

endmodule

[tb/tb.sv]
module tb;
    import bol_pkg::*;

    localparam int DEPTH       = DEFAULT_DEPTH;
    localparam int DATA_W      = DEFAULT_DATA_WIDTH;
    localparam int CYCLE_LIMIT = 400000;

    // Action codes the block does not define; they must be refused
    localparam logic [ACTION_W-1:0] ACT_RSVD6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_RSVD7 = 3'd7;

    // Receiver behavior
    localparam int READY_ALWAYS = 0;
    localparam int READY_RANDOM = 1;
    localparam int READY_STALLS = 2;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] count;
        logic               is_full;
        logic               is_empty;
    } list_result_t;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;   // position[3:0], value[35:4]
    logic [S_TUSER_W-1:0] s_tuser     = '0;   // action[2:0]
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;            // ok[0], read_value[32:1], count[37:33],
                                              // is_full[38], is_empty[39]

    // Shadow copy of the list and its limit
    logic [VALUE_W-1:0] shadow_entries [DEPTH];
    int                 shadow_count = 0;
    logic [CAP_W-1:0]   shadow_limit = CAP_W'(DEPTH);

    list_result_t pending_results [$];

    int  error_count     = 0;
    int  requests_sent   = 0;
    int  results_checked = 0;
    int  limit_settings  = 0;
    int  cycle_count     = 0;
    int  burst_left      = 0;
    int  stall_left      = 0;
    bit  sender_bursty   = 1'b0;
    int  ready_mode      = READY_ALWAYS;

    bounded_ordered_list #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic int effective_limit();
        return (shadow_limit < DEPTH) ? int'(shadow_limit) : DEPTH;
    endfunction

    // Apply one request to the shadow list and return the word it should produce
    function automatic list_result_t apply_request(logic [ACTION_W-1:0] act,
                                                   logic [POS_W-1:0] pos,
                                                   logic [VALUE_W-1:0] val);
        list_result_t res;
        int           lim;
        int           p;
        int           i;
        res = '0;
        lim = effective_limit();
        p   = int'(pos);
        case (act)
            ACT_PUSH:
                if (shadow_count < lim)
                begin
                    shadow_entries[shadow_count] = val;
                    shadow_count++;
                    res.ok = 1'b1;
                end
            ACT_POP:
                if (shadow_count > 0)
                begin
                    shadow_count--;
                    res.ok = 1'b1;
                end
            ACT_INSERT:
                if (shadow_count < lim && p <= shadow_count)
                begin
                    for (i = shadow_count; i > p; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[p] = val;
                    shadow_count++;
                    res.ok = 1'b1;
                end
            ACT_ERASE:
                if (p < shadow_count)
                begin
                    for (i = p; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                    res.ok = 1'b1;
                end
            ACT_READ:
                if (p < shadow_count)
                begin
                    res.read_value = shadow_entries[p];
                    res.ok = 1'b1;
                end
            ACT_CLEAR:
            begin
                shadow_count = 0;
                res.ok = 1'b1;
            end
            default: ;
        endcase
        res.count    = COUNT_W'(shadow_count);
        res.is_full  = (shadow_count >= lim);
        res.is_empty = (shadow_count == 0);
        return res;
    endfunction

    // Offer one request word, hold it until taken, then maybe open a gap
    task automatic send_request(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                                logic [VALUE_W-1:0] val);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-VALUE_W-POS_W){1'b0}}, val, pos};
        s_tuser  <= act;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(apply_request(act, pos, val));
        requests_sent++;
        if (sender_bursty)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
                                                  : $urandom_range(1, 6);
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(0, 12);
            end
        end
    endtask

    // Drop valid before anything that must not see a stale word
    task automatic hold_sender();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write the limit only with the list idle
    task automatic set_capacity_limit(logic [CAP_W-1:0] lim);
        hold_sender();
        wait_for_results();
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_limit = lim;
        limit_settings++;
    endtask

    // Receiver stall pattern
    always @(negedge clk)
    begin
        case (ready_mode)
            READY_RANDOM:
                m_tready <= ($urandom_range(0, 3) != 0);
            READY_STALLS:
                if (stall_left > 0)
                begin
                    stall_left <= stall_left - 1;
                    m_tready   <= 1'b0;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    stall_left <= $urandom_range(1, 20);
                    m_tready   <= 1'b0;
                end
                else
                    m_tready <= 1'b1;
            default:
                m_tready <= 1'b1;
        endcase
    end

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no request waiting: %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_tdata[0] !== want.ok)
                begin
                    $error("ok: expected %0d, got %0d", want.ok, m_tdata[0]);
                    error_count++;
                end
                if (m_tdata[32:1] !== want.read_value)
                begin
                    $error("read_value: expected %h, got %h", want.read_value, m_tdata[32:1]);
                    error_count++;
                end
                if (m_tdata[37:33] !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, m_tdata[37:33]);
                    error_count++;
                end
                if (m_tdata[38] !== want.is_full)
                begin
                    $error("is_full: expected %0d, got %0d", want.is_full, m_tdata[38]);
                    error_count++;
                end
                if (m_tdata[39] !== want.is_empty)
                begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, m_tdata[39]);
                    error_count++;
                end
            end
        end
    end

    // Refusals on an empty list straight out of reset
    task automatic test_empty_list_refusals();
        send_request(ACT_POP,   4'd0,  32'h0);
        send_request(ACT_READ,  4'd0,  32'h0);
        send_request(ACT_ERASE, 4'd15, 32'hFFFF_FFFF);
    endtask

    // Each edit action, reads and the reserved codes, at the ends of the list and past them
    task automatic test_edit_actions();
        send_request(ACT_PUSH,   4'd0,  32'h0000_0000);
        send_request(ACT_PUSH,   4'd15, 32'hFFFF_FFFF);
        send_request(ACT_INSERT, 4'd0,  32'hA5A5_5A5A);
        send_request(ACT_INSERT, 4'd3,  32'h1234_5678);   // append at the end
        send_request(ACT_INSERT, 4'd5,  32'hDEAD_BEEF);   // past the end
        send_request(ACT_READ,   4'd1,  32'h0);
        send_request(ACT_READ,   4'd15, 32'h0);
        send_request(ACT_ERASE,  4'd1,  32'h0);
        send_request(ACT_ERASE,  4'd2,  32'h0);           // last entry
        send_request(ACT_READ,   4'd0,  32'h0);
        send_request(ACT_RSVD6,  4'd0,  32'h5555_5555);
        send_request(ACT_RSVD7,  4'd15, 32'hAAAA_AAAA);
        send_request(ACT_CLEAR,  4'd0,  32'h0);
    endtask

    // Full list, a limit lowered below the count, and a zero limit
    task automatic test_capacity_limits();
        set_capacity_limit(5'd2);
        send_request(ACT_PUSH,   4'd0, 32'h0000_0001);
        send_request(ACT_PUSH,   4'd0, 32'h0000_0002);
        send_request(ACT_PUSH,   4'd0, 32'h0000_0003);
        send_request(ACT_INSERT, 4'd0, 32'h0000_0004);
        set_capacity_limit(5'd1);
        send_request(ACT_PUSH,   4'd0, 32'h0000_0005);
        send_request(ACT_READ,   4'd1, 32'h0);
        set_capacity_limit(5'd0);
        send_request(ACT_CLEAR,  4'd0, 32'h0);
        send_request(ACT_PUSH,   4'd0, 32'h0000_0006);
        send_request(ACT_INSERT, 4'd0, 32'h0000_0007);
    endtask

    // One random request, mostly well formed for the current count
    task automatic send_random_request();
        logic [ACTION_W-1:0] act;
        logic [POS_W-1:0]    pos;
        logic [VALUE_W-1:0]  val;
        int                  pick;
        pick = $urandom_range(0, 7);
        val  = (pick == 0) ? '0 : (pick == 1) ? '1 : VALUE_W'($urandom);
        pos  = POS_W'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < 15)
            act = ACTION_W'($urandom_range(0, 7));
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                act = ACT_PUSH;
            else if (pick < 45)
            begin
                act = ACT_INSERT;
                pos = POS_W'($urandom_range(0, (shadow_count > 15) ? 15 : shadow_count));
            end
            else if (pick < 65)
                act = ACT_ERASE;
            else if (pick < 90)
                act = ACT_READ;
            else if (pick < 97)
                act = ACT_POP;
            else
                act = ACT_CLEAR;
            if ((act == ACT_ERASE || act == ACT_READ) && shadow_count > 0)
                pos = POS_W'($urandom_range(0, shadow_count - 1));
        end
        send_request(act, pos, val);
    endtask

    // Random traffic over a series of limits and flow-control patterns
    task automatic test_random_traffic();
        logic [CAP_W-1:0] limits [10];
        int               phase;
        int               n;
        limits = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd5, 5'd16, 5'd15, 5'd2, 5'd16, 5'd9};
        limits[9] = CAP_W'($urandom_range(1, 16));
        for (phase = 0; phase < 10; phase++)
        begin
            set_capacity_limit(limits[phase]);
            sender_bursty = (phase % 3 != 0);
            ready_mode    = phase % 3;
            burst_left    = 0;
            for (n = 0; n < ((limits[phase] < 2) ? 60 : 147); n++)
                send_random_request();
        end
        sender_bursty = 1'b0;
        ready_mode    = READY_ALWAYS;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_empty_list_refusals();
        test_edit_actions();
        test_capacity_limits();
        test_random_traffic();

        hold_sender();
        wait_for_results();
        repeat (40) @(posedge clk);

        $display("tb: %0d requests sent, %0d result words checked", requests_sent,
                 results_checked);
        $display("tb: push/pop/insert/erase/read/clear and reserved actions over %0d limits",
                 limit_settings);
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
